>>> rtl/core/bism_pkg.sv
// Shared types, constants and helpers of the integer stack machine.
package bism_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 31;
    localparam int CMD_W       = 4;

    localparam logic signed [VAL_W:0] VALUE_LIMIT = 32'sd1000000000;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN  = 4'd0,
        CMD_NUM    = 4'd1,
        CMD_POP    = 4'd2,
        CMD_INV    = 4'd3,
        CMD_DUP    = 4'd4,
        CMD_SWP    = 4'd5,
        CMD_ADD    = 4'd6,
        CMD_SUB    = 4'd7,
        CMD_MUL    = 4'd8,
        CMD_DIV    = 4'd9,
        CMD_MOD    = 4'd10,
        CMD_FINISH = 4'd11
    } cmd_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic signed [VAL_W-1:0] operand;
    } item_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               err;
    } status_t;

    function automatic logic in_range(input logic signed [VAL_W:0] v);
        return (v <= VALUE_LIMIT) && (v >= -VALUE_LIMIT);
    endfunction

endpackage

>>> rtl/core/bounded_integer_stack_machine.sv
// Top level of the bounded signed integer stack machine.
//
//   channel   direction   handshake          payload
//   items     in          push / full        cmd, operand
//   results   out         empty / pop        answer, failed
//
// In the back end each item is taken and then executed; pops and binary
// operations on a stack deeper than two add a refill step, as the second
// value is read back from the stack RAM through its registered read port.
// MUL adds a step for the registered product; DIV and MOD wait for the
// divider, which produces one quotient bit per cycle.
// Reset empties the stack and clears the error flag; the RAM is not cleared.
// A two-entry queue lets the front keep taking items while the back works;
// a finish waits as well while an earlier result has not been transferred.
module bounded_integer_stack_machine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [bism_pkg::CMD_W-1:0]        cmd,
    input  logic signed [bism_pkg::VAL_W-1:0] operand,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [bism_pkg::VAL_W-1:0] answer,
    output logic                              failed
);
    import bism_pkg::*;

    logic      head_valid;
    item_t     head;
    logic      take;
    status_t   status;

    bism_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .cmd        (cmd),
        .operand    (operand),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .take       (take)
    );

    bism_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .take       (take),
        .empty      (empty),
        .pop        (pop),
        .answer     (answer),
        .failed     (failed),
        .status     (status)
    );

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.depth <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth exceeds capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && failed) |-> (answer == '0))
        else $error("failed result carries a nonzero answer");

    a_answer_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !failed) |-> ((answer <= 31'sd1000000000) && (answer >= -31'sd1000000000)))
        else $error("answer out of range");

endmodule

>>> rtl/core/bism_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bism_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/bism_front.sv
// Front end: accepts items, drops unused codes and queues the rest.
module bism_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic [bism_pkg::CMD_W-1:0]       cmd,
    input  logic signed [bism_pkg::VAL_W-1:0] operand,
    output logic                             full,
    output logic                             head_valid,
    output bism_pkg::item_t                  head,
    input  logic                             take
);
    import bism_pkg::*;

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       enq;
    logic       deq;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    // Codes above finish are accepted but never reach the back end.
    assign enq = push && !full && (cmd <= CMD_W'(CMD_FINISH));
    assign deq = take && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ enq;
        rd_ptr_next = rd_ptr_reg ^ deq;
        cnt_next    = cnt_reg + 2'(enq) - 2'(deq);
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= '{cmd: cmd_t'(cmd), operand: operand};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/core/bism_divider.sv
// Radix-2 restoring signed divider, truncating toward zero.
module bism_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [bism_pkg::VAL_W-1:0] dividend,
    input  logic signed [bism_pkg::VAL_W-1:0] divisor,
    output logic                              done,
    output logic signed [bism_pkg::VAL_W-1:0] quotient,
    output logic signed [bism_pkg::VAL_W-1:0] remainder
);
    import bism_pkg::*;

    localparam int CNT_W = $clog2(VAL_W + 1);

    logic [VAL_W-1:0] rem_reg, quo_reg, dvs_reg;
    logic             neg_q_reg, neg_r_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [VAL_W:0]   shifted;
    logic [VAL_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[VAL_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            quo_reg   <= dividend[VAL_W-1] ? VAL_W'(-dividend) : dividend;
            dvs_reg   <= divisor[VAL_W-1] ? VAL_W'(-divisor) : divisor;
            neg_q_reg <= dividend[VAL_W-1] ^ divisor[VAL_W-1];
            neg_r_reg <= dividend[VAL_W-1];
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits.
            if (!trial[VAL_W])
            begin
                rem_reg <= trial[VAL_W-1:0];
                quo_reg <= {quo_reg[VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[VAL_W-1:0];
                quo_reg <= {quo_reg[VAL_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(VAL_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = neg_q_reg ? VAL_W'(-quo_reg) : quo_reg;
    assign remainder = neg_r_reg ? VAL_W'(-rem_reg) : rem_reg;

endmodule

>>> rtl/core/bism_back.sv
// Back end: executes queued items on a cached two-value stack top plus a RAM.
module bism_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  bism_pkg::item_t                   head,
    output logic                              take,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [bism_pkg::VAL_W-1:0] answer,
    output logic                              failed,
    output bism_pkg::status_t                 status
);
    import bism_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_MUL    = 5'b00100,
        S_DIV    = 5'b01000,
        S_REFILL = 5'b10000
    } state_t;

    localparam int PROD_W = 2 * VAL_W;
    localparam logic signed [PROD_W-1:0] PROD_LIMIT = PROD_W'(VALUE_LIMIT);

    state_t                    state_reg, state_next;
    cmd_t                      op_reg;
    logic signed [VAL_W-1:0]   val_reg;
    logic signed [VAL_W-1:0]   tos_reg, tos_next;
    logic signed [VAL_W-1:0]   nos_reg, nos_next;
    logic [DEPTH_W-1:0]        depth_reg, depth_next;
    logic                      err_reg, err_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [VAL_W-1:0]   ans_reg, ans_next;
    logic                      fail_reg, fail_next;
    logic                      res_valid_reg, res_valid_next;

    logic                      ram_we, ram_re;
    logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
    logic [VAL_W-1:0]          ram_rdata;

    logic                      div_start, div_done;
    logic signed [VAL_W-1:0]   div_q, div_r;
    logic signed [VAL_W:0]     sum;
    logic signed [VAL_W:0]     div_res;

    bism_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (nos_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bism_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (nos_reg),
        .divisor   (tos_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // A finish is taken only when the result slot is free by the next cycle.
    assign take = (state_reg == S_IDLE) && head_valid &&
                  !((head.cmd == CMD_FINISH) && res_valid_reg && !pop);

    assign ram_waddr = ADDR_W'(depth_reg - DEPTH_W'(2));
    assign ram_raddr = ADDR_W'(depth_reg - DEPTH_W'(3));

    assign sum = (op_reg == CMD_ADD) ? ({nos_reg[VAL_W-1], nos_reg} + {tos_reg[VAL_W-1], tos_reg})
                                     : ({nos_reg[VAL_W-1], nos_reg} - {tos_reg[VAL_W-1], tos_reg});
    assign div_res = (op_reg == CMD_DIV) ? {div_q[VAL_W-1], div_q} : {div_r[VAL_W-1], div_r};

    always_comb
    begin
        state_next     = state_reg;
        tos_next       = tos_reg;
        nos_next       = nos_reg;
        depth_next     = depth_reg;
        err_next       = err_reg;
        ans_next       = ans_reg;
        fail_next      = fail_reg;
        res_valid_next = res_valid_reg && !pop;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                if (op_reg == CMD_BEGIN)
                begin
                    tos_next   = val_reg;
                    depth_next = DEPTH_W'(1);
                    err_next   = !in_range({val_reg[VAL_W-1], val_reg});
                    if (err_next)
                    begin
                        depth_next = '0;
                    end
                end
                else if (op_reg == CMD_FINISH)
                begin
                    fail_next      = err_reg || (depth_reg != DEPTH_W'(1));
                    ans_next       = fail_next ? '0 : tos_reg;
                    res_valid_next = 1'b1;
                    depth_next     = '0;
                    err_next       = 1'b0;
                end
                else if (!err_reg)
                begin
                    unique case (op_reg) inside
                        CMD_NUM, CMD_DUP:
                        begin
                            if ((op_reg == CMD_DUP) && (depth_reg == '0))
                            begin
                                err_next = 1'b1;
                            end
                            else if (((op_reg == CMD_NUM) &&
                                      !in_range({val_reg[VAL_W-1], val_reg})) ||
                                     (depth_reg == DEPTH_W'(STACK_DEPTH)))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                // The old second value spills to the RAM.
                                ram_we     = (depth_reg >= DEPTH_W'(2));
                                nos_next   = tos_reg;
                                tos_next   = (op_reg == CMD_NUM) ? val_reg : tos_reg;
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            if (depth_reg == '0)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                tos_next   = nos_reg;
                                depth_next = depth_reg - 1'b1;
                                ram_re     = (depth_reg >= DEPTH_W'(3));
                                state_next = ram_re ? S_REFILL : S_IDLE;
                            end
                        end
                        CMD_INV:
                        begin
                            if (depth_reg == '0)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                tos_next = -tos_reg;
                            end
                        end
                        CMD_SWP:
                        begin
                            if (depth_reg < DEPTH_W'(2))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                tos_next = nos_reg;
                                nos_next = tos_reg;
                            end
                        end
                        CMD_ADD, CMD_SUB:
                        begin
                            if ((depth_reg < DEPTH_W'(2)) || !in_range(sum))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                tos_next   = sum[VAL_W-1:0];
                                depth_next = depth_reg - 1'b1;
                                ram_re     = (depth_reg >= DEPTH_W'(3));
                                state_next = ram_re ? S_REFILL : S_IDLE;
                            end
                        end
                        CMD_MUL:
                        begin
                            if (depth_reg < DEPTH_W'(2))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_MUL;
                            end
                        end
                        CMD_DIV, CMD_MOD:
                        begin
                            if ((depth_reg < DEPTH_W'(2)) || (tos_reg == '0))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                state_next = S_IDLE;
                if ((prod_reg > PROD_LIMIT) || (prod_reg < -PROD_LIMIT))
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    tos_next   = prod_reg[VAL_W-1:0];
                    depth_next = depth_reg - 1'b1;
                    ram_re     = (depth_reg >= DEPTH_W'(3));
                    state_next = ram_re ? S_REFILL : S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_IDLE;
                    if (!in_range(div_res))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        tos_next   = div_res[VAL_W-1:0];
                        depth_next = depth_reg - 1'b1;
                        ram_re     = (depth_reg >= DEPTH_W'(3));
                        state_next = ram_re ? S_REFILL : S_IDLE;
                    end
                end
            end
            S_REFILL:
            begin
                nos_next   = ram_rdata;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg  <= head.cmd;
            val_reg <= head.operand;
        end
        prod_reg <= nos_reg * tos_reg;
        tos_reg  <= tos_next;
        nos_reg  <= nos_next;
        ans_reg  <= ans_next;
        fail_reg <= fail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign empty  = !res_valid_reg;
    assign answer = ans_reg;
    assign failed = fail_reg;
    assign status = '{depth: depth_reg, err: err_reg};

endmodule
